// ===== design/heap_indexed_tree_traversal_unit_macros.svh =====
// Assertion macros shared by the tree traversal unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef HEAP_INDEXED_TREE_TRAVERSAL_UNIT_MACROS_SVH
`define HEAP_INDEXED_TREE_TRAVERSAL_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HITT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define HITT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hitt_pkg.sv =====
// Package for the heap-indexed tree traversal unit: constants, item types,
// controller state and the command/status structs. No dependencies.
package hitt_pkg;

  localparam int NODE_SLOTS  = 15;
  localparam int VALUE_BITS  = 8;
  localparam int SLOT_BITS   = 4;
  localparam int CUR_BITS    = SLOT_BITS + 1;
  localparam int STORE_DEPTH = 2 ** SLOT_BITS;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam logic [1:0] ORD_PRE      = 2'd0;
  localparam logic [1:0] ORD_IN       = 2'd1;
  localparam logic [1:0] ORD_POST     = 2'd2;
  localparam logic [1:0] ORD_POST_ALT = 2'd3;

  typedef struct packed {
    logic                  kind;
    logic [SLOT_BITS-1:0]  slot;
    logic [VALUE_BITS-1:0] node_value;
    logic [1:0]            order;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] visited_value;
    logic [SLOT_BITS-1:0]  visited_slot;
    logic                  last;
    logic                  tree_empty;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_ENTER,
    ST_UP,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic load_we;     // write node store from the input transaction
    logic start;       // latch order, cursor to root
    logic empty_emit;  // produce the empty-tree result
    logic go_left;     // cursor <= 2*cursor
    logic go_right;    // cursor <= 2*cursor + 1
    logic go_up;       // cursor <= cursor / 2, remember side
    logic emit;        // visit node at cursor
    logic flush;       // release held result flagged last
  } ctrl_cmd_t;

  typedef struct packed {
    logic cur_empty;
    logic cur_is_root;
    logic from_right;
    logic ord_pre;
    logic ord_in;
    logic ord_post;
    logic pend_v;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== design/hitt_in_if.sv =====
// Input channel of the traversal unit: valid/ready plus one input item.
// Depends on hitt_pkg.
interface hitt_in_if;
  import hitt_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/hitt_out_if.sv =====
// Output channel of the traversal unit: valid/ready plus one result item.
// Depends on hitt_pkg.
interface hitt_out_if;
  import hitt_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/heap_indexed_tree_traversal_unit.sv =====
// Heap-indexed binary tree traversal unit (pre-, in- and post-order).
// Load transaction: no result. Start: one result per visited node.
// One cursor step a cycle unless held by a full output; one result is held back so the
// final one can be flagged last.
// Reset (async, active low) empties every node slot and idles the walker.
module heap_indexed_tree_traversal_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  hitt_in_if.sink    in_i,
  hitt_out_if.source out_o
);
  import hitt_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  hitt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.payload.kind),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hitt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_i.payload),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.payload)
  );

endmodule

// ===== design/hitt_ctrl.sv =====
// Traversal controller: walks the heap-ordered tree one step a cycle unless the output stalls, and
// issues commands to the datapath. Depends on hitt_pkg and the macro header.
`include "heap_indexed_tree_traversal_unit_macros.svh"

module hitt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_kind_i,
  output logic               in_ready_o,
  input  hitt_pkg::dp_sts_t  sts_i,
  output hitt_pkg::ctrl_cmd_t cmd_o
);
  import hitt_pkg::*;

  state_e state_q, state_d;
  logic   emit_ok;

  // a new visit may displace the held result only if the output can take it
  assign emit_ok = !sts_i.pend_v || sts_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_kind_i == KIND_START) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (!sts_i.cur_empty) state_d = ST_ENTER;
        else if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_ENTER: begin
        if (sts_i.cur_empty) state_d = ST_UP;
      end
      ST_UP: begin
        if (!sts_i.from_right) begin
          if (!sts_i.ord_in || emit_ok) state_d = ST_ENTER;
        end else if ((!sts_i.ord_post || emit_ok) && sts_i.cur_is_root) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start   = (in_kind_i == KIND_START);
          cmd_o.load_we = (in_kind_i == KIND_LOAD);
        end
      end
      ST_ROOT: begin
        cmd_o.empty_emit = sts_i.cur_empty && sts_i.out_free;
      end
      ST_ENTER: begin
        if (sts_i.cur_empty) begin
          cmd_o.go_up = 1'b1;
        end else if (!sts_i.ord_pre || emit_ok) begin
          cmd_o.emit    = sts_i.ord_pre;
          cmd_o.go_left = 1'b1;
        end
      end
      ST_UP: begin
        if (!sts_i.from_right) begin
          if (!sts_i.ord_in || emit_ok) begin
            cmd_o.emit     = sts_i.ord_in;
            cmd_o.go_right = 1'b1;
          end
        end else if (!sts_i.ord_post || emit_ok) begin
          cmd_o.emit  = sts_i.ord_post;
          cmd_o.go_up = !sts_i.cur_is_root;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  `HITT_ASSERT_NOW(a_idle_nothing_held, clk_i, rst_ni, state_q == ST_IDLE, !sts_i.pend_v, "result held while idle")
  `HITT_ASSERT_NOW(a_emit_has_room, clk_i, rst_ni, cmd_o.emit, !sts_i.pend_v || sts_i.out_free, "visit would drop a held result")
  `HITT_ASSERT_NEXT(a_flush_clears, clk_i, rst_ni, cmd_o.flush, !sts_i.pend_v, "held result survives flush")

endmodule

// ===== design/hitt_dp.sv =====
// Traversal datapath: node store, cursor, held result and output register.
// Depends on hitt_pkg.
module hitt_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hitt_pkg::ctrl_cmd_t cmd_i,
  input  hitt_pkg::in_item_t  in_item_i,
  output hitt_pkg::dp_sts_t   sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output hitt_pkg::out_item_t out_item_o
);
  import hitt_pkg::*;

  logic [VALUE_BITS-1:0] store_q [STORE_DEPTH];

  logic [CUR_BITS-1:0]   cur_q, cur_d;
  logic                  from_right_q, from_right_d;
  logic [1:0]            order_q, order_d;
  logic                  pend_v_q, pend_v_d;
  logic [VALUE_BITS-1:0] pend_value_q;
  logic [SLOT_BITS-1:0]  pend_slot_q;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;
  logic [VALUE_BITS-1:0] cur_value;
  logic                  load_ok;

  assign cur_value = store_q[cur_q[SLOT_BITS-1:0]];
  assign load_ok   = cmd_i.load_we && (in_item_i.slot != '0) &&
                     ({1'b0, in_item_i.slot} <= CUR_BITS'(NODE_SLOTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) store_q[i] <= '0;
    end else if (load_ok) begin
      store_q[in_item_i.slot] <= in_item_i.node_value;
    end
  end

  // cursor moves in heap index space: children 2s, 2s+1, parent s/2
  always_comb begin
    cur_d        = cur_q;
    from_right_d = from_right_q;
    order_d      = order_q;
    if (cmd_i.start) begin
      cur_d   = CUR_BITS'(1);
      order_d = in_item_i.order;
    end else if (cmd_i.go_left) begin
      cur_d = {cur_q[CUR_BITS-2:0], 1'b0};
    end else if (cmd_i.go_right) begin
      cur_d = {cur_q[CUR_BITS-2:0], 1'b1};
    end else if (cmd_i.go_up) begin
      cur_d        = cur_q >> 1;
      from_right_d = cur_q[0];
    end
  end

  always_comb begin
    pend_v_d    = pend_v_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    if (cmd_i.emit) begin
      pend_v_d = 1'b1;
      if (pend_v_q) begin
        out_valid_d = 1'b1;
        out_item_d  = '{visited_value: pend_value_q, visited_slot: pend_slot_q,
                        last: 1'b0, tree_empty: 1'b0};
      end
    end
    if (cmd_i.flush) begin
      pend_v_d    = 1'b0;
      out_valid_d = 1'b1;
      out_item_d  = '{visited_value: pend_value_q, visited_slot: pend_slot_q,
                      last: 1'b1, tree_empty: 1'b0};
    end
    if (cmd_i.empty_emit) begin
      out_valid_d = 1'b1;
      out_item_d  = '{visited_value: '0, visited_slot: '0,
                      last: 1'b1, tree_empty: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q        <= '0;
      from_right_q <= 1'b0;
      order_q      <= ORD_PRE;
      pend_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cur_q        <= cur_d;
      from_right_q <= from_right_d;
      order_q      <= order_d;
      pend_v_q     <= pend_v_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    if (cmd_i.emit) begin
      pend_value_q <= cur_value;
      pend_slot_q  <= cur_q[SLOT_BITS-1:0];
    end
  end

  always_comb begin
    sts_o.cur_empty   = (cur_q == '0) || (cur_q > CUR_BITS'(NODE_SLOTS)) ||
                        (cur_value == '0);
    sts_o.cur_is_root = (cur_q == CUR_BITS'(1));
    sts_o.from_right  = from_right_q;
    sts_o.ord_pre     = (order_q == ORD_PRE);
    sts_o.ord_in      = (order_q == ORD_IN);
    sts_o.ord_post    = (order_q == ORD_POST) || (order_q == ORD_POST_ALT);
    sts_o.pend_v      = pend_v_q;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
